>>> hw/rtl/sm4_pkg.sv
package sm4_pkg;

   localparam int BLOCK_W   = 128;
   localparam int WORD_W    = 32;
   localparam int ROUNDS    = 32;
   localparam int RIDX_W    = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   // Write and read controls of the round key register file.
   typedef struct packed {
      logic              we;
      logic [RIDX_W-1:0] waddr;
      logic [RIDX_W-1:0] raddr;
   } rk_ctl_type;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte-wise S-box substitution of a word.
   function automatic logic [31:0] tau(input logic [31:0] a);
      tau = {SBOX_TABLE[a[31:24]], SBOX_TABLE[a[23:16]],
             SBOX_TABLE[a[15:8]],  SBOX_TABLE[a[7:0]]};
   endfunction

   // Key schedule constant: byte j of word i is (4i + j) * 7 mod 256.
   function automatic logic [31:0] ck_word(input logic [RIDX_W-1:0] idx);
      logic [7:0]  base;
      logic [7:0]  n;
      logic [31:0] w;
      base = {1'b0, idx, 2'b00};
      w    = '0;
      for (int j = 0; j < 4; j++) begin
         n = base + 8'(j);
         w[31-8*j -: 8] = (n << 3) - n;
      end
      ck_word = w;
   endfunction

endpackage

>>> hw/rtl/sm4_round_unit.sv
module sm4_round_unit
   import sm4_pkg::*;
(
   input  logic [BLOCK_W-1:0] work_words,
   input  logic [WORD_W-1:0]  round_key,
   input  logic               key_sched,
   output logic [WORD_W-1:0]  new_word
);

   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] sub;
   logic [WORD_W-1:0] lin_data;
   logic [WORD_W-1:0] lin_key;

   always_comb begin
      mix = work_words[95:64] ^ work_words[63:32] ^ work_words[31:0] ^ round_key;
      sub = tau(mix);
      lin_data = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
               ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
      lin_key  = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};
      new_word = work_words[127:96] ^ (key_sched ? lin_key : lin_data);
   end

endmodule

>>> hw/rtl/sm4_key_regs.sv
module sm4_key_regs
   import sm4_pkg::*;
(
   input  logic              clock,
   input  rk_ctl_type        ctl,
   input  logic [WORD_W-1:0] wdata,
   output logic [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] keys_ff [ROUNDS];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         keys_ff[ctl.waddr] <= wdata;
      end
   end

   assign rdata = keys_ff[ctl.raddr];

endmodule

>>> hw/rtl/sm4_block_cipher_ecb_cbc.sv
// A block passes from the input transfer through the load, round and finish states
// to the output register; when the round keys are not current, a key expansion comes first.
// The single shared round unit serves one key-schedule or cipher round per cycle, and
// a new block is taken only when the engine is idle again.
// Reset is synchronous and active high; it clears the control and configuration
// registers, the chaining value and the key-valid flag, so the first block
// always expands the keys.
module sm4_block_cipher_ecb_cbc
   import sm4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BLOCK_W-1:0]    req_tdata,   // block_high [63:0], block_low [127:64]
   input  logic                  req_tuser,   // restart_chain
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BLOCK_W-1:0]    rsp_tdata,   // result_high [63:0], result_low [127:64]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IV_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IV_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR      = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [RIDX_W-1:0]   cnt_ff, cnt_in;
   logic                keys_valid_ff, keys_valid_in;
   logic [BLOCK_W-1:0]  key_ff, iv_ff, chain_ff, chain_in;
   logic                cbc_ff, dir_ff;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic [BLOCK_W-1:0]  work_ff, work_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                key_sched;
   logic [WORD_W-1:0]   rk_rdata;
   logic [WORD_W-1:0]   unit_key;
   logic [WORD_W-1:0]   new_word;
   logic [BLOCK_W-1:0]  rounds_out;
   logic [BLOCK_W-1:0]  cipher_out;
   logic [63:0]         blk_high, blk_low;
   rk_ctl_type          rk_ctl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign key_sched = (state_ff == ST_EXPAND);
   assign unit_key  = key_sched ? ck_word(cnt_ff) : rk_rdata;

   always_comb begin
      rk_ctl.we    = key_sched;
      rk_ctl.waddr = cnt_ff;
      // Decryption walks the forward key schedule backwards.
      rk_ctl.raddr = dir_ff ? ~cnt_ff : cnt_ff;
   end

   sm4_key_regs u_key_regs (
      .clock (clock),
      .ctl   (rk_ctl),
      .wdata (new_word),
      .rdata (rk_rdata)
   );

   sm4_round_unit u_round_unit (
      .work_words (work_ff),
      .round_key  (unit_key),
      .key_sched  (key_sched),
      .new_word   (new_word)
   );

   // Words are held big-endian: the block's first word sits in the top bits.
   assign blk_high   = blk_ff[127:64];
   assign blk_low    = blk_ff[63:0];
   assign rounds_out = {work_ff[31:0], work_ff[63:32], work_ff[95:64], work_ff[127:96]};
   assign cipher_out = (cbc_ff && dir_ff) ? (rounds_out ^ chain_ff) : rounds_out;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      keys_valid_in = keys_valid_ff;
      chain_in      = chain_ff;
      blk_in        = blk_ff;
      work_in       = work_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               blk_in = {req_tdata[63:0], req_tdata[127:64]};
               if (req_tuser) begin
                  chain_in = iv_ff;
               end
               cnt_in = '0;
               if (keys_valid_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  work_in  = key_ff ^ {FK0, FK1, FK2, FK3};
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            work_in = {work_ff[95:0], new_word};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == RIDX_W'(ROUNDS - 1)) begin
               keys_valid_in = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         ST_LOAD: begin
            work_in  = (cbc_ff && !dir_ff) ? (blk_ff ^ chain_ff) : blk_ff;
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in = {work_ff[95:0], new_word};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == RIDX_W'(ROUNDS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cipher_out[63:0], cipher_out[127:64]};
               if (cbc_ff) begin
                  chain_in = dir_ff ? {blk_high, blk_low} : cipher_out;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we && ((csr_index == REG_KEY_HIGH) || (csr_index == REG_KEY_LOW)
                     || (csr_index == REG_DIR))) begin
         keys_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         keys_valid_ff <= 1'b0;
         chain_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         key_ff        <= '0;
         iv_ff         <= '0;
         cbc_ff        <= 1'b0;
         dir_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         keys_valid_ff <= keys_valid_in;
         chain_ff      <= chain_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_KEY_HIGH: key_ff[127:64] <= csr_wdata;
               REG_KEY_LOW:  key_ff[63:0]   <= csr_wdata;
               REG_IV_HIGH:  iv_ff[127:64]  <= csr_wdata;
               REG_IV_LOW:   iv_ff[63:0]    <= csr_wdata;
               REG_MODE:     cbc_ff         <= csr_wdata[0];
               REG_DIR:      dir_ff         <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> hw/rtl/sm4_checker.sv
module sm4_protocol_checker
   import sm4_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [BLOCK_W-1:0]    rsp_tdata
);

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The engine works on one block at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a block is in progress");

   // No result can appear in the cycle after a transfer into an empty engine.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   // After reset the engine is empty and ready.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("engine not idle after reset");

endmodule

bind sm4_block_cipher_ecb_cbc sm4_protocol_checker u_sm4_checker (.*);
